[src/scps_pkg.sv]
package scps_pkg;

  localparam int unsigned XY_W     = 13;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned CFG_AW   = 5;
  localparam int unsigned CFG_DW   = 32;
  localparam int unsigned IN_TDW   = 32;
  localparam int unsigned OUT_TDW  = 64;

  localparam logic [PIX_W-1:0] BYTE_MASK = 32'hFEFE_FEFF;

  typedef enum logic [2:0] {
    REG_SCALE_MODE  = 3'd0,
    REG_INTERLACED  = 3'd1,
    REG_FRAME_WIDTH = 3'd2,
    REG_H_OFFSET    = 3'd3,
    REG_V_OFFSET    = 3'd4
  } scps_reg_t;

  typedef enum logic [1:0] {
    ROW_FIRST  = 2'd0,
    ROW_SECOND = 2'd1,
    ROW_DIM    = 2'd2
  } scps_row_t;

  typedef struct packed {
    logic [XY_W-1:0]  xa;
    logic [XY_W-1:0]  xb;
    logic [PIX_W-1:0] pa;
    logic [PIX_W-1:0] pb;
    logic [XY_W-1:0]  y;
    logic             two;
    logic             ilace;
  } scps_item_t;

  function automatic logic [PIX_W-1:0] dim_word(input logic [PIX_W-1:0] p);
    logic [PIX_W-1:0] m;
    m = p & BYTE_MASK;
    return {1'b0, m[PIX_W-1:1]};
  endfunction

  function automatic logic [PIX_W-1:0] mean_word(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] s;
    s = (a & BYTE_MASK) + (b & BYTE_MASK);
    return {1'b0, s[PIX_W-1:1]};
  endfunction

endpackage

[src/scanline_pixel_scaler.sv]
// Scanline pixel scaler. Takes one 32-bit source pixel per transfer in raster order and
// emits surface writes {dest_x, dest_y, pixel_value}, three output rows per source line
// (row 2 dimmed when interlaced is set). Mode 0 gives six writes per pixel; mode 1 gives
// three writes for the first pixel of each group of four, six for the others, and none
// for pixels past the last full group of a line. The output channel carries one write
// per cycle while out_tready is high; the next pixel is taken in the same cycle as the
// last write of the current one. A held item register feeds the output directly;
// config writes must be made only while the block has no writes pending; the block
// itself does not enforce this.
module scanline_pixel_scaler
  import scps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned MAX_LINES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_TDW-1:0]   in_tdata,   // [31:0] src_pixel
  input  logic                in_tuser,   // [0] frame_start
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TDW-1:0]  out_tdata,  // [12:0] dest_x, [25:13] dest_y,
                                          // [57:26] pixel_value, [63:58] zero
  output logic                out_tlast,  // last
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [CFG_DW-1:0]   cfg_pwdata,
  output logic [CFG_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(MAX_LINES - 1);
  localparam logic [XY_W-1:0]   MAXW      = XY_W'(MAX_WIDTH);

  logic        scale_mode_r;
  logic        interlaced_r;
  logic [11:0] frame_width_r;
  logic [11:0] h_offset_r;
  logic [11:0] v_offset_r;

  logic [COL_W-1:0]  col_cnt_r,  col_cnt_nxt;
  logic [LINE_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [PIX_W-1:0]  prev_pix_r;

  logic       busy_r, busy_nxt;
  scps_row_t  row_r, row_nxt;
  logic       sel_r, sel_nxt;
  scps_item_t item_r, item_nxt;

  logic cfg_wr;
  logic in_fire, out_fire, out_last;

  logic [XY_W-1:0]   width_w, lim_w, fw_w;
  logic [XY_W-1:0]   c0, c1, c2, g, g7, k2, cola, colb, h_w, l1x;
  logic [LINE_W-1:0] l0, l1;
  logic [1:0]        k;
  logic [PIX_W-1:0]  pix, cur_p, pix_out;
  logic              emit;

  function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] l);
    return (l == LINE_LAST) ? '0 : LINE_W'(l + 1'b1);
  endfunction

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r  <= 1'b0;
      interlaced_r  <= 1'b1;
      frame_width_r <= 12'd640;
      h_offset_r    <= '0;
      v_offset_r    <= '0;
    end else if (cfg_wr) begin
      case (scps_reg_t'(cfg_paddr[4:2]))
        REG_SCALE_MODE:  scale_mode_r  <= cfg_pwdata[0];
        REG_INTERLACED:  interlaced_r  <= cfg_pwdata[0];
        REG_FRAME_WIDTH: frame_width_r <= cfg_pwdata[11:0];
        REG_H_OFFSET:    h_offset_r    <= cfg_pwdata[11:0];
        REG_V_OFFSET:    v_offset_r    <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (scps_reg_t'(cfg_paddr[4:2]))
      REG_SCALE_MODE:  cfg_prdata = {31'd0, scale_mode_r};
      REG_INTERLACED:  cfg_prdata = {31'd0, interlaced_r};
      REG_FRAME_WIDTH: cfg_prdata = {20'd0, frame_width_r};
      REG_H_OFFSET:    cfg_prdata = {20'd0, h_offset_r};
      REG_V_OFFSET:    cfg_prdata = {20'd0, v_offset_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // output side
  assign out_last   = (row_r == ROW_DIM) && (sel_r || !item_r.two);
  assign out_tvalid = busy_r;
  assign out_tlast  = out_last;
  assign out_fire   = out_tvalid && out_tready;
  assign in_tready  = !busy_r || (out_tready && out_last);
  assign in_fire    = in_tvalid && in_tready;

  assign cur_p   = sel_r ? item_r.pb : item_r.pa;
  assign pix_out = ((row_r == ROW_DIM) && item_r.ilace) ? dim_word(cur_p) : cur_p;
  assign out_tdata = {6'd0, pix_out, XY_W'(item_r.y + XY_W'(row_r)),
                      (sel_r ? item_r.xb : item_r.xa)};

  // input side
  always_comb begin
    pix  = in_tdata[PIX_W-1:0];
    fw_w = {1'b0, frame_width_r};
    if (fw_w == '0) begin
      width_w = XY_W'(1);
    end else if (fw_w > MAXW) begin
      width_w = MAXW;
    end else begin
      width_w = fw_w;
    end
    lim_w = {width_w[XY_W-1:2], 2'b00};

    c0 = in_tuser ? '0 : XY_W'(col_cnt_r);
    l0 = in_tuser ? '0 : line_cnt_r;
    if (c0 >= width_w) begin
      c1 = '0;
      l1 = line_inc(l0);
    end else begin
      c1 = c0;
      l1 = l0;
    end
    c2 = c1 + XY_W'(1);
    if (c2 >= width_w) begin
      col_cnt_nxt  = '0;
      line_cnt_nxt = line_inc(l1);
    end else begin
      col_cnt_nxt  = COL_W'(c2);
      line_cnt_nxt = l1;
    end

    h_w = {1'b0, h_offset_r};
    l1x = XY_W'(l1);
    g   = c1 >> 2;
    g7  = (g << 3) - g;
    k   = c1[1:0];
    k2  = XY_W'({k, 1'b0});
    if (!scale_mode_r) begin
      cola = c1 << 1;
      colb = (c1 << 1) | XY_W'(1);
    end else if (k == 2'd0) begin
      cola = g7;
      colb = g7;
    end else begin
      cola = g7 + k2 - XY_W'(1);
      colb = g7 + k2;
    end
    emit = !scale_mode_r || (c1 < lim_w);

    item_nxt.xa    = h_w + cola;
    item_nxt.xb    = h_w + colb;
    item_nxt.pa    = (scale_mode_r && (k != 2'd0)) ? mean_word(prev_pix_r, pix) : pix;
    item_nxt.pb    = pix;
    item_nxt.y     = {1'b0, v_offset_r} + (l1x << 1) + l1x;
    item_nxt.two   = !scale_mode_r || (k != 2'd0);
    item_nxt.ilace = interlaced_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    sel_nxt  = sel_r;
    if (out_fire) begin
      if (out_last) begin
        busy_nxt = 1'b0;
      end else if (row_r == ROW_DIM) begin
        row_nxt = ROW_FIRST;
        sel_nxt = 1'b1;
      end else begin
        row_nxt = scps_row_t'(row_r + 2'd1);
      end
    end
    if (in_fire && emit) begin
      busy_nxt = 1'b1;
      row_nxt  = ROW_FIRST;
      sel_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      row_r      <= ROW_FIRST;
      sel_r      <= 1'b0;
      col_cnt_r  <= '0;
      line_cnt_r <= '0;
      prev_pix_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
      sel_r  <= sel_nxt;
      if (in_fire) begin
        col_cnt_r  <= col_cnt_nxt;
        line_cnt_r <= line_cnt_nxt;
        prev_pix_r <= pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      item_r <= item_nxt;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && busy_r) |-> (out_fire && out_last))
    else $error("input taken while writes still pending");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (row_r != 2'd3))
    else $error("row index out of range");

  a_single_col_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && sel_r) |-> item_r.two)
    else $error("second column selected on a single-column item");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

[test/scps_checker.sv]
`timescale 1ns / 1ps
module scps_checker
  import scps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned MAX_LINES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [IN_TDW-1:0]  in_tdata,   // [31:0] src_pixel
  input  logic               in_tuser,   // [0] frame_start
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [OUT_TDW-1:0] out_tdata,  // [12:0] dest_x, [25:13] dest_y,
                                         // [57:26] pixel_value, [63:58] zero
  input  logic               out_tlast,  // last
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  input  logic               cfg_pready,
  output int unsigned        fail_count,
  output int unsigned        pending
);

  typedef struct packed {
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic [PIX_W-1:0] pix;
    logic             last;
  } surface_write_t;

  surface_write_t   pending_writes[$];
  surface_write_t   batch[6];
  int unsigned      batch_n;

  logic             mode_q;
  logic             ilace_q;
  logic [11:0]      width_q;
  logic [11:0]      hoff_q;
  logic [11:0]      voff_q;
  logic [11:0]      col_q;
  logic [9:0]       line_q;
  logic [PIX_W-1:0] prev_q;

  function automatic logic [PIX_W-1:0] halve_bytes(input logic [PIX_W-1:0] p);
    return (p & BYTE_MASK) >> 1;
  endfunction

  function automatic logic [PIX_W-1:0] blend_pair(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] sum;
    sum = (a & BYTE_MASK) + (b & BYTE_MASK);
    return sum >> 1;
  endfunction

  task automatic advance_line();
    col_q  = '0;
    line_q = (32'(line_q) == MAX_LINES - 1) ? '0 : line_q + 10'd1;
  endtask

  task automatic add_column(input int unsigned col, input logic [PIX_W-1:0] p);
    surface_write_t w;
    for (int r = 0; r < 3; r++) begin
      w.x    = XY_W'(32'(hoff_q) + col);
      w.y    = XY_W'(32'(voff_q) + 3 * 32'(line_q) + 32'(r));
      w.pix  = (r == int'(ROW_DIM) && ilace_q) ? halve_bytes(p) : p;
      w.last = 1'b0;
      batch[batch_n] = w;
      batch_n++;
    end
  endtask

  task automatic predict_surface_writes(input logic [PIX_W-1:0] p, input logic fs);
    int unsigned w_eff;
    int unsigned g;
    int unsigned k;
    w_eff = 32'(width_q);
    if (w_eff < 1) w_eff = 1;
    if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
    batch_n = 0;
    if (fs) begin
      col_q  = '0;
      line_q = '0;
    end
    if (32'(col_q) >= w_eff) advance_line();
    if (!mode_q) begin
      add_column(2 * 32'(col_q), p);
      add_column(2 * 32'(col_q) + 1, p);
    end else if (32'(col_q) < (w_eff / 4) * 4) begin
      g = 32'(col_q) / 4;
      k = 32'(col_q) % 4;
      if (k == 0) begin
        add_column(7 * g, p);
      end else begin
        add_column(7 * g + 2 * k - 1, blend_pair(prev_q, p));
        add_column(7 * g + 2 * k, p);
      end
    end
    prev_q = p;
    col_q  = col_q + 12'd1;
    if (32'(col_q) >= w_eff) advance_line();
    for (int i = 0; i < int'(batch_n); i++) begin
      if (i == int'(batch_n) - 1) batch[i].last = 1'b1;
      pending_writes.push_back(batch[i]);
    end
  endtask

  task automatic flag_field(input string name, input logic [PIX_W-1:0] want,
                            input logic [PIX_W-1:0] got);
    fail_count++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
  endtask

  task automatic check_write();
    surface_write_t want;
    surface_write_t got;
    got.x    = out_tdata[XY_W-1:0];
    got.y    = out_tdata[2*XY_W-1:XY_W];
    got.pix  = out_tdata[2*XY_W+PIX_W-1:2*XY_W];
    got.last = out_tlast;
    if (pending_writes.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected write: expected none, actual x=%h y=%h pix=%h last=%b",
               $time, got.x, got.y, got.pix, got.last);
    end else begin
      want = pending_writes.pop_front();
      if (got.x !== want.x) flag_field("dest_x", 32'(want.x), 32'(got.x));
      if (got.y !== want.y) flag_field("dest_y", 32'(want.y), 32'(got.y));
      if (got.pix !== want.pix) flag_field("pixel_value", want.pix, got.pix);
      if (got.last !== want.last) flag_field("last", 32'(want.last), 32'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q  = 1'b0;
      ilace_q = 1'b1;
      width_q = 12'd640;
      hoff_q  = '0;
      voff_q  = '0;
      col_q   = '0;
      line_q  = '0;
      prev_q  = '0;
      pending_writes.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (scps_reg_t'(cfg_paddr[CFG_AW-1:2]))
          REG_SCALE_MODE:  mode_q  = cfg_pwdata[0];
          REG_INTERLACED:  ilace_q = cfg_pwdata[0];
          REG_FRAME_WIDTH: width_q = cfg_pwdata[11:0];
          REG_H_OFFSET:    hoff_q  = cfg_pwdata[11:0];
          REG_V_OFFSET:    voff_q  = cfg_pwdata[11:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_write();
      if (in_tvalid && in_tready) predict_surface_writes(in_tdata[PIX_W-1:0], in_tuser);
    end
    pending <= pending_writes.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import scps_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_TDW-1:0]  in_tdata = '0;   // [31:0] src_pixel
  logic               in_tuser = 1'b0; // [0] frame_start
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_TDW-1:0] out_tdata;       // [12:0] dest_x, [25:13] dest_y,
                                       // [57:26] pixel_value, [63:58] zero
  logic               out_tlast;       // last
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]  cfg_paddr = '0;
  logic [CFG_DW-1:0]  cfg_pwdata = '0;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        quiet_cycles = 0;

  scanline_pixel_scaler u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  scps_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("scanline_pixel_scaler regression: fail");
      $finish;
    end
  end

  task automatic set_pace(input int unsigned pace);
    case (pace)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 75;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 75;
      end
      default: begin
        send_idle_pct  = 17;
        recv_stall_pct = 17;
      end
    endcase
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold off input until every predicted write has been seen
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input scps_reg_t idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic mode, input logic ilace, input logic [11:0] w,
                             input logic [11:0] h, input logic [11:0] v);
    drain();
    cfg_write(REG_SCALE_MODE, CFG_DW'(mode));
    cfg_write(REG_INTERLACED, CFG_DW'(ilace));
    cfg_write(REG_FRAME_WIDTH, CFG_DW'(w));
    cfg_write(REG_H_OFFSET, CFG_DW'(h));
    cfg_write(REG_V_OFFSET, CFG_DW'(v));
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return BYTE_MASK;
      3: return 32'h0101_0101;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] pick_offset();
    case ($urandom_range(3))
      0: return '0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int unsigned pace, input int unsigned items);
    logic        mode;
    logic [11:0] w;
    mode = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: w = 12'($urandom_range(4, 8));
      1: w = 12'($urandom_range(9, 40));
      2: w = 12'hFFF;
      3: w = mode ? 12'd4 : 12'($urandom_range(0, 3));
      default: w = 12'($urandom_range(4, 16));
    endcase
    reconfigure(mode, 1'($urandom_range(1)), w, pick_offset(), pick_offset());
    set_pace(pace);
    repeat (items) begin
      if ($urandom_range(39) == 0) drain();
      send_pixel(pick_pixel(), $urandom_range(19) == 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_pace(0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h8000_0001, 1'b0);
    send_pixel(32'h0101_0101, 1'b0);

    // four-to-seven with offsets at max, partial group at line end
    reconfigure(1'b1, 1'b0, 12'd5, 12'hFFF, 12'hFFF);
    set_pace(3);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0001, 1'b0);
    send_pixel(32'hFEFE_FEFF, 1'b0);
    send_pixel(32'h1234_5678, 1'b0);
    send_pixel(32'h8765_4321, 1'b0);

    reconfigure(1'b0, 1'b1, 12'd0, 12'd0, 12'd0);
    send_pixel(32'hA5A5_A5A5, 1'b0);
    send_pixel(32'h5A5A_5A5A, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);

    // switch mode, then narrow the line, part way through
    reconfigure(1'b0, 1'b1, 12'd8, 12'd17, 12'd33);
    send_pixel(32'h1111_1111, 1'b1);
    send_pixel(32'hF0F0_F0F0, 1'b0);
    send_pixel(32'h0F0F_0F0F, 1'b0);
    reconfigure(1'b1, 1'b1, 12'd8, 12'd17, 12'd33);
    send_pixel(32'hFFFF_0000, 1'b0);
    send_pixel(32'h0000_FFFF, 1'b0);
    reconfigure(1'b0, 1'b1, 12'd3, 12'd17, 12'd33);
    send_pixel(32'hDEAD_BEEF, 1'b0);
    send_pixel(32'hCAFE_F00D, 1'b1);

    for (int unsigned i = 0; i < 12; i++) random_phase(i % 4, 37);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("scanline_pixel_scaler regression: pass");
    else
      $display("scanline_pixel_scaler regression: fail");
    $finish;
  end

endmodule

[filelist.f]
src/scps_pkg.sv
src/scanline_pixel_scaler.sv
test/scps_checker.sv
test/testbench.sv
